>>> sv/bounded_sequence_list_engine_defines.svh
// Assertion macros used by the list engine back module.
`ifndef BOUNDED_SEQUENCE_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_SEQUENCE_LIST_ENGINE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BSLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define BSLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/bsle_pkg.sv
`default_nettype none
package bsle_pkg;

  typedef enum logic [3:0] {
    OP_INS_FRONT = 4'd0,
    OP_INS_BACK  = 4'd1,
    OP_DEL_FRONT = 4'd2,
    OP_DEL_BACK  = 4'd3,
    OP_DEL_AT    = 4'd4,
    OP_FIND      = 4'd5,
    OP_MAX       = 4'd6,
    OP_INVERT    = 4'd7,
    OP_READ_ALL  = 4'd8,
    OP_FRONT     = 4'd9,
    OP_BACK      = 4'd10,
    OP_COUNT     = 4'd11,
    OP_CLEAR     = 4'd12
  } op_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  // Classified command as it travels from the front to the back
  typedef struct packed {
    op_t        op;
    logic [6:0] pos;
    logic [6:0] end_pos;
  } cmd_t;

endpackage
`default_nettype wire

>>> sv/bsle_ram.sv
`default_nettype none
module bsle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/bsle_front.sv
`default_nettype none
module bsle_front
  import bsle_pkg::*;
#(
  parameter int ELEMENT_BITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [3:0]              in_command,
  input  wire logic signed [31:0]      in_value,
  input  wire logic [6:0]              in_position,
  input  wire logic [6:0]              in_end_position,
  output logic                         q_valid,
  output cmd_t                         q_cmd,
  output logic [ELEMENT_BITS-1:0]      q_value,
  input  wire logic                    q_pop
);

  cmd_t                    q_cmd_r [2];
  logic [ELEMENT_BITS-1:0] q_val_r [2];
  logic                    wr_ptr_r;
  logic                    rd_ptr_r;
  logic [1:0]              fill_r;
  logic                    push;
  logic                    taken;

  assign in_stall = (fill_r == 2'd2);
  assign taken    = in_valid && !in_stall;
  // Drop unknown commands: they give no result
  assign push     = taken && (in_command <= OP_CLEAR);

  assign q_valid = (fill_r != 2'd0);
  assign q_cmd   = q_cmd_r[rd_ptr_r];
  assign q_value = q_val_r[rd_ptr_r];

  // Hold classified transactions until the back takes them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !q_pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (!push && q_pop) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_cmd_r[wr_ptr_r].op      <= op_t'(in_command);
      q_cmd_r[wr_ptr_r].pos     <= in_position;
      q_cmd_r[wr_ptr_r].end_pos <= in_end_position;
      q_val_r[wr_ptr_r]         <= ELEMENT_BITS'(in_value);
    end
  end

endmodule
`default_nettype wire

>>> sv/bsle_back.sv
`default_nettype none
`include "bounded_sequence_list_engine_defines.svh"
module bsle_back
  import bsle_pkg::*;
#(
  parameter int MAX_ENTRIES  = 64,
  parameter int ELEMENT_BITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    q_valid,
  input  wire cmd_t                    q_cmd,
  input  wire logic [ELEMENT_BITS-1:0] q_value,
  output logic                         q_pop,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [2:0]                   out_status,
  output logic signed [31:0]           out_element,
  output logic [5:0]                   out_index,
  output logic [6:0]                   out_entry_count,
  output logic                         out_last
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int PW = (CW > 7) ? CW : 7;
  localparam logic [AW:0]   ENTRIES_W = (AW + 1)'(MAX_ENTRIES);
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_ENTRIES - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_GOT, S_SH_RD, S_SH_WR,
    S_SW_A, S_SW_B, S_SW_C, S_SW_D, S_EMIT
  } state_t;

  state_t                  state_r;
  op_t                     op_r;
  logic [ELEMENT_BITS-1:0] val_r;
  logic [ELEMENT_BITS-1:0] tmp_r;
  logic [ELEMENT_BITS-1:0] best_r;
  logic [AW-1:0]           cur_r;
  logic [AW-1:0]           p1_r;
  logic [AW-1:0]           p2_r;
  logic [AW-1:0]           head_r;
  logic [CW-1:0]           cnt_r;
  logic [2:0]              res_status_r;
  logic [ELEMENT_BITS-1:0] res_elem_r;
  logic [AW-1:0]           res_idx_r;
  logic                    res_last_r;
  logic                    out_valid_r;

  logic                    we;
  logic [AW-1:0]           waddr;
  logic [ELEMENT_BITS-1:0] wdata;
  logic [AW-1:0]           raddr;
  logic [ELEMENT_BITS-1:0] rdata;

  logic [CW-1:0]           cnt_m1;
  logic [AW-1:0]           last_pos;
  logic                    cur_is_last;
  logic                    is_full;
  logic [PW-1:0]           pos_x;
  logic [PW-1:0]           end_x;
  logic [PW-1:0]           cnt_x;
  logic [AW-1:0]           head_dec;
  logic                    out_free;
  logic [AW:0]             p1_plus2;

  // Map a list position onto a slot of the circular store
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= ENTRIES_W) begin
      s = s - ENTRIES_W;
    end
    return s[AW-1:0];
  endfunction

  assign cnt_m1      = cnt_r - CW'(1);
  assign last_pos    = AW'(cnt_m1);
  assign cur_is_last = (CW'(cur_r) == cnt_m1);
  assign is_full     = (cnt_r == FULL_CNT);
  assign pos_x       = PW'(q_cmd.pos);
  assign end_x       = PW'(q_cmd.end_pos);
  assign cnt_x       = PW'(cnt_r);
  assign head_dec    = (head_r == '0) ? LAST_SLOT : head_r - AW'(1);
  assign out_free    = !out_valid_r || !out_stall;
  assign p1_plus2    = (AW + 1)'(p1_r) + (AW + 1)'(2);
  assign q_pop       = (state_r == S_IDLE) && q_valid;

  // Drive the store ports from the current step
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = val_r;
    raddr = wrap_add(head_r, cur_r);
    case (state_r)
      S_IDLE: begin
        wdata = q_value;
        if (q_valid && !is_full) begin
          if (q_cmd.op == OP_INS_FRONT) begin
            we    = 1'b1;
            waddr = head_dec;
          end else if (q_cmd.op == OP_INS_BACK) begin
            we    = 1'b1;
            waddr = wrap_add(head_r, AW'(cnt_r));
          end
        end
      end
      S_SH_RD: raddr = wrap_add(head_r, cur_r + AW'(1));
      S_SH_WR: begin
        we    = 1'b1;
        waddr = wrap_add(head_r, cur_r);
        wdata = rdata;
      end
      S_SW_A: raddr = wrap_add(head_r, p1_r);
      S_SW_B: raddr = wrap_add(head_r, p2_r);
      S_SW_C: begin
        we    = 1'b1;
        waddr = wrap_add(head_r, p1_r);
        wdata = rdata;
      end
      S_SW_D: begin
        we    = 1'b1;
        waddr = wrap_add(head_r, p2_r);
        wdata = tmp_r;
      end
      default: ;
    endcase
  end

  bsle_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (1 << AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Sequence each command over the store and hand results to the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            op_r         <= q_cmd.op;
            val_r        <= q_value;
            res_status_r <= ST_OK;
            res_elem_r   <= '0;
            res_idx_r    <= '0;
            res_last_r   <= 1'b1;
            cur_r        <= '0;
            state_r      <= S_EMIT;
            if (q_cmd.op == OP_INS_FRONT || q_cmd.op == OP_INS_BACK) begin
              if (is_full) begin
                res_status_r <= ST_FULL;
              end else begin
                res_elem_r <= q_value;
                cnt_r      <= cnt_r + CW'(1);
                if (q_cmd.op == OP_INS_FRONT) begin
                  head_r <= head_dec;
                end else begin
                  res_idx_r <= AW'(cnt_r);
                end
              end
            end else if (q_cmd.op == OP_COUNT) begin
              res_status_r <= ST_OK;
            end else if (cnt_r == '0) begin
              res_status_r <= ST_EMPTY;
            end else begin
              case (q_cmd.op)
                OP_DEL_FRONT, OP_FIND, OP_MAX, OP_READ_ALL, OP_FRONT: begin
                  state_r <= S_RD;
                end
                OP_DEL_BACK, OP_BACK: begin
                  cur_r   <= last_pos;
                  state_r <= S_RD;
                end
                OP_DEL_AT: begin
                  if (pos_x >= cnt_x) begin
                    res_status_r <= ST_INVALID;
                  end else begin
                    cur_r   <= AW'(q_cmd.pos);
                    state_r <= S_RD;
                  end
                end
                OP_INVERT: begin
                  if (pos_x >= cnt_x || end_x >= cnt_x || pos_x > end_x) begin
                    res_status_r <= ST_INVALID;
                  end else if (pos_x != end_x) begin
                    p1_r    <= AW'(q_cmd.pos);
                    p2_r    <= AW'(q_cmd.end_pos);
                    state_r <= S_SW_A;
                  end
                end
                OP_CLEAR: begin
                  cnt_r  <= '0;
                  head_r <= '0;
                end
                default: state_r <= S_IDLE;
              endcase
            end
          end
        end
        S_RD: state_r <= S_GOT;
        S_GOT: begin
          res_elem_r <= rdata;
          res_idx_r  <= cur_r;
          state_r    <= S_EMIT;
          case (op_r)
            OP_DEL_FRONT: begin
              head_r <= wrap_add(head_r, AW'(1));
              cnt_r  <= cnt_m1;
            end
            OP_DEL_BACK: cnt_r <= cnt_m1;
            OP_DEL_AT: begin
              if (cur_is_last) begin
                cnt_r <= cnt_m1;
              end else begin
                state_r <= S_SH_RD;
              end
            end
            OP_FIND: begin
              if (rdata == val_r) begin
                res_elem_r <= val_r;
              end else if (cur_is_last) begin
                res_status_r <= ST_NOT_FOUND;
                res_elem_r   <= '0;
                res_idx_r    <= '0;
              end else begin
                cur_r   <= cur_r + AW'(1);
                state_r <= S_RD;
              end
            end
            OP_MAX: begin
              if (cur_r == '0 || $signed(rdata) > $signed(best_r)) begin
                best_r    <= rdata;
                p1_r      <= cur_r;
              end else begin
                res_elem_r <= best_r;
                res_idx_r  <= p1_r;
              end
              if (!cur_is_last) begin
                cur_r   <= cur_r + AW'(1);
                state_r <= S_RD;
              end
            end
            OP_READ_ALL: res_last_r <= cur_is_last;
            default: ;
          endcase
        end
        // Shift the tail down by one after a delete
        S_SH_RD: state_r <= S_SH_WR;
        S_SH_WR: begin
          if (CW'(cur_r) + CW'(1) == cnt_m1) begin
            cnt_r   <= cnt_m1;
            state_r <= S_EMIT;
          end else begin
            cur_r   <= cur_r + AW'(1);
            state_r <= S_SH_RD;
          end
        end
        // Swap one pair of the range per pass
        S_SW_A: state_r <= S_SW_B;
        S_SW_B: begin
          tmp_r   <= rdata;
          state_r <= S_SW_C;
        end
        S_SW_C: state_r <= S_SW_D;
        S_SW_D: begin
          p1_r <= p1_r + AW'(1);
          p2_r <= p2_r - AW'(1);
          if (p1_plus2 < (AW + 1)'(p2_r)) begin
            state_r <= S_SW_A;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_status      <= res_status_r;
            out_element     <= 32'($signed(res_elem_r));
            out_index       <= 6'(res_idx_r);
            out_entry_count <= 7'(cnt_r);
            out_last        <= res_last_r;
            if (op_r == OP_READ_ALL && !res_last_r) begin
              cur_r   <= cur_r + AW'(1);
              state_r <= S_RD;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

  `BSLE_ASSERT(a_cnt_bound, cnt_r <= FULL_CNT, "entry count beyond capacity")
  `BSLE_ASSERT(a_pop_idle, q_pop |-> state_r == S_IDLE, "queue popped while busy")
  `BSLE_ASSERT_NEXT(a_ins_grow, q_pop && q_cmd.op == OP_INS_FRONT && !is_full, cnt_r == CW'($past(cnt_r) + CW'(1)), "insert did not grow list")
  `BSLE_ASSERT(a_emit_src, $rose(out_valid_r) |-> $past(state_r) == S_EMIT, "result raised outside emit")
endmodule
`default_nettype wire

>>> sv/bounded_sequence_list_engine.sv
// Bounded list engine: keeps up to MAX_ENTRIES signed words in a circular
// store with one write and one registered read port. Commands enter a
// two-deep queue, so the input side stalls only while it is full.
// Inserts, count and clear need no store read; delete at either end and
// front/back reads take one; find and max read entry by entry; delete at
// a position shifts the tail entry by entry; invert swaps each pair with
// two reads and two writes; read all emits one entry per read. The single
// registered read port of the store sets this pacing. No clearing pass is
// needed after reset. Unknown commands are dropped without a result.
`default_nettype none
module bounded_sequence_list_engine
  import bsle_pkg::*;
#(
  parameter int MAX_ENTRIES  = 64,
  parameter int ELEMENT_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [3:0]         in_command,
  input  wire logic signed [31:0] in_value,
  input  wire logic [6:0]         in_position,
  input  wire logic [6:0]         in_end_position,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_status,
  output logic signed [31:0]      out_element,
  output logic [5:0]              out_index,
  output logic [6:0]              out_entry_count,
  output logic                    out_last
);

  logic                    q_valid;
  cmd_t                    q_cmd;
  logic [ELEMENT_BITS-1:0] q_value;
  logic                    q_pop;

  bsle_front #(
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_value        (in_value),
    .in_position     (in_position),
    .in_end_position (in_end_position),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_value         (q_value),
    .q_pop           (q_pop)
  );

  bsle_back #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_value         (q_value),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_element     (out_element),
    .out_index       (out_index),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire
